@@ src/cbc_pkg.sv @@
`timescale 1ns / 1ps
package cbc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_FRAC_BITS  = 4;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = 30;
	localparam int TOTAL_W    = 21;
	localparam int CENT_W     = 14;
	localparam int SEL_W      = 2;
	localparam int IMG_W_W    = 11;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_PAD_W  = OUT_DATA_W - 3 * PIX_W - 2 * CENT_W;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [15:0] IMG_W_RESET = 16'd640;

	localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
	localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_GREEN = 2'd2;

	localparam logic REG_COLOR_SEL   = 1'b0;
	localparam logic REG_IMAGE_WIDTH = 1'b1;

	// window bounds
	localparam logic [PIX_W-1:0] RED_R_MIN   = 8'd170;
	localparam logic [PIX_W-1:0] RED_G_MAX   = 8'd93;
	localparam logic [PIX_W-1:0] RED_B_MAX   = 8'd81;
	localparam logic [PIX_W-1:0] BLUE_B_MIN  = 8'd220;
	localparam logic [PIX_W-1:0] BLUE_G_MAX  = 8'd165;
	localparam logic [PIX_W-1:0] BLUE_R_MAX  = 8'd55;
	localparam logic [PIX_W-1:0] GREEN_G_MIN = 8'd176;
	localparam logic [PIX_W-1:0] GREEN_R_MAX = 8'd78;
	localparam logic [PIX_W-1:0] GREEN_B_MAX = 8'd135;

	typedef struct packed {
		logic [PIX_W-1:0]   blue;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   red;
		logic               last;
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
		logic [TOTAL_W-1:0] total;
	} cbc_item_t;

	typedef enum logic {
		BK_PASS,
		BK_DIV
	} cbc_back_state_t;

endpackage

@@ src/color_blob_centroid.sv @@
`timescale 1ns / 1ps
// Path: a plain pixel item passes through a queue entry and the output register to m_*; a frame's
// last item waits in the queue while two restoring dividers (one bit per cycle) run, then loads m_*.
// Throughput: one pixel per cycle within a frame while m_tready stays high. A frame end holds the back end
// until both dividers finish; the 4-entry queue takes input until full, then s_tready drops.
// Async reset (arst_n low) clears counters, sums, queue and output valid;
// color_select resets to 0, image_width to 640.
module color_blob_centroid #(
	parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = cbc_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16]
	input  logic [cbc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_blue[7:0], out_green[15:8], out_red[23:16], centroid_col[37:24],
	// centroid_row[51:38], zero pad [55:52]
	output logic [cbc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cbc_pkg::APB_AW-1:0]     paddr,
	input  logic [cbc_pkg::APB_DW-1:0]     pwdata,
	output logic [cbc_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);
	import cbc_pkg::*;

	logic [SEL_W-1:0]   color_select_q;
	logic [IMG_W_W-1:0] image_width_q;
	logic               cfg_wr;
	logic               push_valid, push_ready, pop_valid, pop_ready;
	cbc_item_t          push_item, pop_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_select_q <= '0;
			image_width_q  <= IMG_W_RESET[IMG_W_W-1:0];
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_COLOR_SEL:   color_select_q <= pwdata[SEL_W-1:0];
				REG_IMAGE_WIDTH: image_width_q  <= pwdata[IMG_W_W-1:0];
				default:         color_select_q <= color_select_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLOR_SEL:   prdata = APB_DW'(color_select_q);
			REG_IMAGE_WIDTH: prdata = APB_DW'(image_width_q);
			default:         prdata = '0;
		endcase
	end

	cbc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.color_select (color_select_q),
		.image_width  (image_width_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	cbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	cbc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ src/cbc_front.sv @@
`timescale 1ns / 1ps
module cbc_front #(
	parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbc_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic [cbc_pkg::SEL_W-1:0]     color_select,
	input  logic [cbc_pkg::IMG_W_W-1:0]   image_width,
	output logic                          push_valid,
	input  logic                          push_ready,
	output cbc_pkg::cbc_item_t            push_item
);
	import cbc_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WCMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

	logic [COL_W-1:0]   column_q;
	logic [ROW_W-1:0]   row_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SUM_W-1:0]   col_sum_q;
	logic [SUM_W-1:0]   row_sum_q;

	logic [PIX_W-1:0]   b, g, r;
	logic               hit;
	logic [PIX_W-1:0]   ob, og, orr;
	logic [TOTAL_W-1:0] total_nx;
	logic [SUM_W-1:0]   col_sum_nx, row_sum_nx;
	logic [SUM_W:0]     col_add, row_add;
	logic [WCMP_W-1:0]  width_ext, eff_width, col_inc;
	logic [ROW_W:0]     row_inc;
	logic               accept;

	assign b = s_tdata[PIX_W-1:0];
	assign g = s_tdata[2*PIX_W-1:PIX_W];
	assign r = s_tdata[3*PIX_W-1:2*PIX_W];

	always_comb begin
		hit = 1'b0;
		case (color_select)
			SEL_RED: begin
				hit = (g > b) && (r > b) && (r >= RED_R_MIN) && (g <= RED_G_MAX)
					&& (b <= RED_B_MAX);
			end
			SEL_BLUE: begin
				hit = (b > r) && (b > g) && (b >= BLUE_B_MIN) && (g <= BLUE_G_MAX)
					&& (r <= BLUE_R_MAX);
			end
			SEL_GREEN: begin
				hit = (g >= GREEN_G_MIN) && (r <= GREEN_R_MAX) && (r != '0)
					&& (b <= GREEN_B_MAX) && (b != '0) && (g > b) && (g > r);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		ob  = b;
		og  = g;
		orr = r;
		if (hit) begin
			ob  = '0;
			og  = '0;
			orr = '0;
			case (color_select)
				SEL_RED:   orr = '1;
				SEL_BLUE:  ob  = '1;
				SEL_GREEN: og  = '1;
				default:   orr = '0;
			endcase
		end
	end

	// saturating accumulators
	assign col_add = {1'b0, col_sum_q} + (SUM_W + 1)'(column_q);
	assign row_add = {1'b0, row_sum_q} + (SUM_W + 1)'(row_q);

	always_comb begin
		total_nx   = total_q;
		col_sum_nx = col_sum_q;
		row_sum_nx = row_sum_q;
		if (hit) begin
			if (total_q != '1) begin
				total_nx = total_q + 1'b1;
			end
			col_sum_nx = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
			row_sum_nx = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
		end
	end

	assign width_ext = WCMP_W'(image_width);
	always_comb begin
		if (width_ext == '0) begin
			eff_width = WCMP_W'(1);
		end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
			eff_width = WCMP_W'(MAX_WIDTH);
		end else begin
			eff_width = width_ext;
		end
	end
	assign col_inc = WCMP_W'(column_q) + 1'b1;
	assign row_inc = (ROW_W + 1)'(row_q) + 1'b1;

	assign accept     = s_tvalid && push_ready;
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_item.blue    = ob;
		push_item.green   = og;
		push_item.red     = orr;
		push_item.last    = s_tlast;
		push_item.col_sum = col_sum_nx;
		push_item.row_sum = row_sum_nx;
		push_item.total   = total_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			total_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				column_q  <= '0;
				row_q     <= '0;
				total_q   <= '0;
				col_sum_q <= '0;
				row_sum_q <= '0;
			end else begin
				total_q   <= total_nx;
				col_sum_q <= col_sum_nx;
				row_sum_q <= row_sum_nx;
				if (col_inc >= eff_width) begin
					column_q <= '0;
					// row sticks at the bottom line on overtall frames
					if (row_inc < (ROW_W + 1)'(MAX_HEIGHT)) begin
						row_q <= row_inc[ROW_W-1:0];
					end
				end else begin
					column_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

endmodule

@@ src/cbc_queue.sv @@
`timescale 1ns / 1ps
module cbc_queue #(
	parameter int DEPTH = cbc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  cbc_pkg::cbc_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output cbc_pkg::cbc_item_t pop_item
);
	import cbc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cbc_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/cbc_div.sv @@
`timescale 1ns / 1ps
module cbc_div #(
	parameter int FRAC_BITS = cbc_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cbc_pkg::SUM_W-1:0]   sum,
	input  logic [cbc_pkg::TOTAL_W-1:0] count,
	output logic                        busy,
	output logic [cbc_pkg::CENT_W-1:0]  quotient
);
	import cbc_pkg::*;

	localparam int DVD_W = SUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TOTAL_W-1:0] rem_q, dvr_q;
	logic [DVD_W-1:0]   dq_q;   // dividend bits shift out, quotient bits shift in
	logic [TOTAL_W:0]   trial, diff;
	logic               fits;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign fits  = (trial >= {1'b0, dvr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvr_q <= count;
			dq_q  <= DVD_W'(sum) << FRAC_BITS;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

	assign busy = busy_q;

	always_comb begin
		if (dvr_q == '0) begin
			quotient = '0;
		end else if (|dq_q[DVD_W-1:CENT_W]) begin
			quotient = '1;
		end else begin
			quotient = dq_q[CENT_W-1:0];
		end
	end

endmodule

@@ src/cbc_back.sv @@
`timescale 1ns / 1ps
module cbc_back #(
	parameter int FRAC_BITS = cbc_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  cbc_pkg::cbc_item_t             pop_item,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cbc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import cbc_pkg::*;

	cbc_back_state_t        state_q, state_nx;
	logic                   out_free, load, div_start;
	logic                   col_busy, row_busy, div_idle;
	logic [CENT_W-1:0]      col_q, row_q;
	logic                   m_valid_q, m_last_q;
	logic [OUT_DATA_W-1:0]  m_data_q;

	assign out_free = !m_valid_q || m_tready;
	assign div_idle = !col_busy && !row_busy;

	cbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sum      (pop_item.col_sum),
		.count    (pop_item.total),
		.busy     (col_busy),
		.quotient (col_q)
	);

	cbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sum      (pop_item.row_sum),
		.count    (pop_item.total),
		.busy     (row_busy),
		.quotient (row_q)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_PASS: begin
				if (pop_valid && pop_item.last) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_idle && out_free) begin
					state_nx = BK_PASS;
				end
			end
			default: begin
				state_nx = BK_PASS;
			end
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		load      = 1'b0;
		div_start = 1'b0;
		case (state_q)
			BK_PASS: begin
				if (pop_valid) begin
					if (pop_item.last) begin
						div_start = 1'b1;
					end else if (out_free) begin
						pop_ready = 1'b1;
						load      = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (div_idle && out_free) begin
					pop_ready = 1'b1;
					load      = 1'b1;
				end
			end
			default: begin
				pop_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_PASS;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				m_valid_q <= 1'b1;
				m_last_q  <= pop_item.last;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == BK_DIV) begin
				m_data_q <= {OUT_PAD_W'(0), row_q, col_q,
					pop_item.red, pop_item.green, pop_item.blue};
			end else begin
				m_data_q <= {OUT_PAD_W'(0), CENT_W'(0), CENT_W'(0),
					pop_item.red, pop_item.green, pop_item.blue};
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = m_data_q;

endmodule

@@ src/cbc_checker.sv @@
`timescale 1ns / 1ps
module cbc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cbc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [cbc_pkg::APB_AW-1:0]     paddr,
	input logic [cbc_pkg::APB_DW-1:0]     pwdata,
	input logic [cbc_pkg::APB_DW-1:0]     prdata,
	input logic                           pready
);
	import cbc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// centroid fields only carry data on a frame end item
	a_cent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[51:24] == '0)
		else $error("centroid nonzero on a non-final item");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:52] == '0)
		else $error("tdata pad bits nonzero");

	// a color select write reads back next cycle
	a_sel_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_SEL)
		|=> paddr[2] || (prdata == APB_DW'($past(pwdata[SEL_W-1:0]))))
		else $error("color select readback mismatch");

endmodule

bind color_blob_centroid cbc_checker u_cbc_checker (.*);
